// File: rtl/ptk_pkg.sv
// ============================================================================
// ptk_pkg: shared types and constants for the priority table selector
// Holds the request and result payloads, mode and status codes, and the
// micro-operation codes that the controller issues to the datapath.
// ============================================================================
package ptk_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int MAX_BATCH_DEF = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Bit pattern of the largest finite single-precision float.
  localparam logic [63:0] MAX_PRIORITY_KEY = 64'h0000_0000_7F7F_FFFF;

  localparam logic [2:0] MODE_SELECT = 3'd0;
  localparam logic [2:0] MODE_SET    = 3'd1;
  localparam logic [2:0] MODE_APPEND = 3'd2;
  localparam logic [2:0] MODE_TRUNC  = 3'd3;
  localparam logic [2:0] MODE_SWAP   = 3'd4;
  localparam logic [2:0] MODE_RESET  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_IDLE        = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD        = 5'd1;
  localparam logic [OP_W-1:0] OP_CAP_P       = 5'd2;
  localparam logic [OP_W-1:0] OP_OH_RD_NEXT  = 5'd3;
  localparam logic [OP_W-1:0] OP_SHIFT_DN    = 5'd4;
  localparam logic [OP_W-1:0] OP_CLR_CUR     = 5'd5;
  localparam logic [OP_W-1:0] OP_PR_RD_H     = 5'd6;
  localparam logic [OP_W-1:0] OP_INC_CUR     = 5'd7;
  localparam logic [OP_W-1:0] OP_INS_INIT    = 5'd8;
  localparam logic [OP_W-1:0] OP_OH_RD_PREV  = 5'd9;
  localparam logic [OP_W-1:0] OP_SHIFT_UP    = 5'd10;
  localparam logic [OP_W-1:0] OP_PLACE       = 5'd11;
  localparam logic [OP_W-1:0] OP_TRUNC_STEP  = 5'd12;
  localparam logic [OP_W-1:0] OP_SET_N       = 5'd13;
  localparam logic [OP_W-1:0] OP_RD_A        = 5'd14;
  localparam logic [OP_W-1:0] OP_RD_B        = 5'd15;
  localparam logic [OP_W-1:0] OP_CAP_B       = 5'd16;
  localparam logic [OP_W-1:0] OP_SWAP_W1     = 5'd17;
  localparam logic [OP_W-1:0] OP_SWAP_W2     = 5'd18;
  localparam logic [OP_W-1:0] OP_RST_STEP    = 5'd19;
  localparam logic [OP_W-1:0] OP_SEL_EMIT    = 5'd20;
  localparam logic [OP_W-1:0] OP_EMIT_STATUS = 5'd21;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  handle_a;
    logic [9:0]  handle_b;
    logic [31:0] priority_key;
    logic [6:0]  pick_count;
    logic [10:0] new_count;
  } in_item_t;

  typedef struct packed {
    logic [9:0] picked_handle;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            set_status;
    logic [1:0]      status_code;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic ha_ok;
    logic hb_ok;
    logic full;
    logic keep_ok;
    logic rm_more;
    logic scan_more;
    logic cmp_hit;
    logic ins_more;
    logic loop_more;
    logic sel_last;
    logic out_free;
  } flags_t;

endpackage

// File: rtl/ptk_if.sv
// ============================================================================
// ptk_if: request and result channels
// Valid/ready channels carrying the request and result payloads.
// ============================================================================
interface ptk_in_if;
  import ptk_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ptk_out_if;
  import ptk_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/ptk_datapath.sv
// ============================================================================
// ptk_datapath: table memories, index registers and result register
// Executes one micro-operation per cycle on the order, position and
// priority memories and reports status flags to the controller.
// ============================================================================
module ptk_datapath import ptk_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int MAX_BATCH = MAX_BATCH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  in_item,
  output flags_t    flags,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = (CW > 10) ? CW : 10;
  localparam int KXW = (CW > 11) ? CW : 11;
  localparam int KW  = KEY_WIDTH;
  localparam logic [KW-1:0] MK = KW'(MAX_PRIORITY_KEY);

  // Memories.
  logic [AW-1:0] oh_mem [CAPACITY];
  logic [AW-1:0] ph_mem [CAPACITY];
  logic [KW-1:0] pr_mem [CAPACITY];

  logic [AW-1:0] oh_raddr, oh_waddr, oh_wdata, oh_rdata;
  logic [AW-1:0] ph_raddr, ph_waddr, ph_wdata, ph_rdata;
  logic [AW-1:0] pr_raddr, pr_waddr;
  logic [KW-1:0] pr_wdata, pr_rdata;
  logic          oh_we, ph_we, pr_we;

  // Working registers.
  logic [CW-1:0] n, cur, ptr;
  logic [2:0]    mode_r;
  logic [9:0]    ha_r, hb_r;
  logic [KW-1:0] key_r, k_a, k_b;
  logic [6:0]    batch_r, picks;
  logic [10:0]   keep_r;
  logic [AW-1:0] tgt, p_a, p_b;
  logic [1:0]    status_r;

  logic [AW-1:0] ha_i, hb_i, cur_i, ptr_i;
  logic [CW:0]   cur_inc;
  logic [CW-1:0] ptr_dec;
  logic          keep_hit;
  logic          emit_sel, emit_st;
  logic [6:0]    batch_in;

  assign ha_i     = AW'(ha_r);
  assign hb_i     = AW'(hb_r);
  assign cur_i    = cur[AW-1:0];
  assign ptr_i    = ptr[AW-1:0];
  assign cur_inc  = {1'b0, cur} + 1'b1;
  assign ptr_dec  = ptr - 1'b1;
  assign keep_hit = KXW'(oh_rdata) < KXW'(keep_r);
  assign emit_sel = cmd.op == OP_SEL_EMIT;
  assign emit_st  = cmd.op == OP_EMIT_STATUS;

  always_ff @(posedge clk) begin
    if (oh_we) begin
      oh_mem[oh_waddr] <= oh_wdata;
    end
    oh_rdata <= oh_mem[oh_raddr];
  end

  always_ff @(posedge clk) begin
    if (ph_we) begin
      ph_mem[ph_waddr] <= ph_wdata;
    end
    ph_rdata <= ph_mem[ph_raddr];
  end

  always_ff @(posedge clk) begin
    if (pr_we) begin
      pr_mem[pr_waddr] <= pr_wdata;
    end
    pr_rdata <= pr_mem[pr_raddr];
  end

  // Memory address and write selection per micro-operation.
  always_comb begin
    oh_raddr = cur_i;
    ph_raddr = ha_i;
    pr_raddr = oh_rdata;
    oh_we = 1'b0; oh_waddr = cur_i; oh_wdata = oh_rdata;
    ph_we = 1'b0; ph_waddr = oh_rdata; ph_wdata = cur_i;
    pr_we = 1'b0; pr_waddr = tgt; pr_wdata = key_r;
    case (cmd.op)
      OP_OH_RD_NEXT: oh_raddr = cur_inc[AW-1:0];
      OP_OH_RD_PREV: oh_raddr = ptr_dec[AW-1:0];
      OP_SHIFT_DN: begin
        oh_we = 1'b1;
        ph_we = 1'b1;
      end
      OP_SHIFT_UP: begin
        oh_we = 1'b1; oh_waddr = ptr_i;
        ph_we = 1'b1; ph_wdata = ptr_i;
      end
      OP_INS_INIT: pr_we = 1'b1;
      OP_PLACE: begin
        oh_we = 1'b1; oh_wdata = tgt;
        ph_we = 1'b1; ph_waddr = tgt;
      end
      OP_TRUNC_STEP: begin
        oh_we = keep_hit; oh_waddr = ptr_i;
        ph_we = keep_hit; ph_wdata = ptr_i;
      end
      OP_RD_A: pr_raddr = ha_i;
      OP_RD_B: begin
        ph_raddr = hb_i;
        pr_raddr = hb_i;
      end
      OP_SWAP_W1: begin
        pr_we = 1'b1; pr_waddr = ha_i; pr_wdata = k_b;
        oh_we = 1'b1; oh_waddr = p_a;  oh_wdata = hb_i;
        ph_we = 1'b1; ph_waddr = ha_i; ph_wdata = p_b;
      end
      OP_SWAP_W2: begin
        pr_we = 1'b1; pr_waddr = hb_i; pr_wdata = k_a;
        oh_we = 1'b1; oh_waddr = p_b;  oh_wdata = ha_i;
        ph_we = 1'b1; ph_waddr = hb_i; ph_wdata = p_a;
      end
      OP_RST_STEP: begin
        oh_we = 1'b1; oh_wdata = cur_i;
        ph_we = 1'b1; ph_waddr = cur_i;
        pr_we = 1'b1; pr_waddr = cur_i; pr_wdata = MK;
      end
      default: begin
      end
    endcase
  end

  // Batch length is clamped to one through the largest batch.
  always_comb begin
    batch_in = in_item.pick_count;
    if (batch_in == 7'd0) begin
      batch_in = 7'd1;
    end else if (batch_in > 7'(MAX_BATCH)) begin
      batch_in = 7'(MAX_BATCH);
    end
  end

  // Entry count, the only table state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cmd.op == OP_PLACE && mode_r == MODE_APPEND) begin
      n <= n + 1'b1;
    end else if (cmd.op == OP_SET_N) begin
      n <= CW'(keep_r);
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r  <= in_item.mode;
        ha_r    <= in_item.handle_a;
        hb_r    <= in_item.handle_b;
        key_r   <= (in_item.mode == MODE_APPEND) ? MK : KW'(in_item.priority_key);
        batch_r <= batch_in;
        keep_r  <= in_item.new_count;
        tgt     <= (in_item.mode == MODE_APPEND) ? n[AW-1:0] : AW'(in_item.handle_a);
        cur     <= '0;
        ptr     <= '0;
        picks   <= '0;
      end
      OP_CAP_P:    cur <= CW'(ph_rdata);
      OP_SHIFT_DN: cur <= cur_inc[CW-1:0];
      OP_CLR_CUR:  cur <= '0;
      OP_INC_CUR:  cur <= cur_inc[CW-1:0];
      OP_INS_INIT: ptr <= (mode_r == MODE_APPEND) ? n : n - 1'b1;
      OP_SHIFT_UP: ptr <= ptr_dec;
      OP_TRUNC_STEP: begin
        cur <= cur_inc[CW-1:0];
        if (keep_hit) begin
          ptr <= ptr + 1'b1;
        end
      end
      OP_RD_B: begin
        p_a <= ph_rdata;
        k_a <= pr_rdata;
      end
      OP_CAP_B: begin
        p_b <= ph_rdata;
        k_b <= pr_rdata;
      end
      OP_RST_STEP: cur <= cur_inc[CW-1:0];
      OP_SEL_EMIT: begin
        picks <= picks + 7'd1;
        cur   <= (cur_inc >= {1'b0, n}) ? '0 : cur_inc[CW-1:0];
      end
      default: begin
      end
    endcase
    if (cmd.op == OP_LOAD) begin
      status_r <= ST_OK;
    end else if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
  end

  // Result register decouples the result channel from the sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_sel || emit_st) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sel) begin
      out_item <= '{picked_handle: 10'(oh_rdata), last: flags.sel_last, status: ST_OK};
    end else if (emit_st) begin
      out_item <= '{picked_handle: 10'd0, last: 1'b1, status: status_r};
    end
  end

  // Status flags for the controller.
  always_comb begin
    flags.empty     = n == '0;
    flags.ha_ok     = XW'(ha_r) < XW'(n);
    flags.hb_ok     = XW'(hb_r) < XW'(n);
    flags.full      = n == CW'(CAPACITY);
    flags.keep_ok   = KXW'(keep_r) <= KXW'(n);
    flags.rm_more   = cur_inc < {1'b0, n};
    flags.scan_more = (mode_r == MODE_APPEND) ? (cur < n) : flags.rm_more;
    flags.cmp_hit   = (mode_r == MODE_APPEND) ? (pr_rdata > key_r) : (pr_rdata >= key_r);
    flags.ins_more  = ptr > cur;
    flags.loop_more = cur < n;
    flags.sel_last  = (picks + 7'd1) == batch_r;
    flags.out_free  = !out_valid || out_ready;
  end

endmodule

// File: rtl/ptk_ctrl.sv
// ============================================================================
// ptk_ctrl: sequencing state machine
// Accepts one request at a time and steps the datapath through the
// micro-operations of its mode.
// ============================================================================
module ptk_ctrl import ptk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  flags_t     flags,
  output cmd_t       cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CHECK    = 5'd1;
  localparam logic [4:0] S_SEL      = 5'd2;
  localparam logic [4:0] S_SEL_RD   = 5'd3;
  localparam logic [4:0] S_SP_CAP   = 5'd4;
  localparam logic [4:0] S_RM       = 5'd5;
  localparam logic [4:0] S_RM_W     = 5'd6;
  localparam logic [4:0] S_SCAN_INI = 5'd7;
  localparam logic [4:0] S_SCAN_RD  = 5'd8;
  localparam logic [4:0] S_SCAN_PR  = 5'd9;
  localparam logic [4:0] S_SCAN_CMP = 5'd10;
  localparam logic [4:0] S_INS_INI  = 5'd11;
  localparam logic [4:0] S_INS      = 5'd12;
  localparam logic [4:0] S_INS_W    = 5'd13;
  localparam logic [4:0] S_TR_RD    = 5'd14;
  localparam logic [4:0] S_TR_W     = 5'd15;
  localparam logic [4:0] S_SW_B     = 5'd16;
  localparam logic [4:0] S_SW_C     = 5'd17;
  localparam logic [4:0] S_SW_1     = 5'd18;
  localparam logic [4:0] S_SW_2     = 5'd19;
  localparam logic [4:0] S_RS       = 5'd20;
  localparam logic [4:0] S_FINISH   = 5'd21;

  logic [4:0] state, state_next;
  logic [2:0] mode_r;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
    end
  end

  // Next state and command for each step.
  always_comb begin
    state_next      = state;
    cmd.op          = OP_IDLE;
    cmd.set_status  = 1'b0;
    cmd.status_code = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (mode_r)
          MODE_SELECT: begin
            if (flags.empty) begin
              cmd.set_status = 1'b1; cmd.status_code = ST_EMPTY;
              state_next = S_FINISH;
            end else begin
              state_next = S_SEL;
            end
          end
          MODE_SET: begin
            if (!flags.ha_ok) begin
              cmd.set_status = 1'b1; cmd.status_code = ST_RANGE;
              state_next = S_FINISH;
            end else begin
              cmd.op     = OP_RD_A;
              state_next = S_SP_CAP;
            end
          end
          MODE_APPEND: begin
            if (flags.full) begin
              cmd.set_status = 1'b1; cmd.status_code = ST_FULL;
              state_next = S_FINISH;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          MODE_TRUNC: begin
            if (!flags.keep_ok) begin
              cmd.set_status = 1'b1; cmd.status_code = ST_RANGE;
              state_next = S_FINISH;
            end else begin
              state_next = S_TR_RD;
            end
          end
          MODE_SWAP: begin
            if (!(flags.ha_ok && flags.hb_ok)) begin
              cmd.set_status = 1'b1; cmd.status_code = ST_RANGE;
              state_next = S_FINISH;
            end else begin
              cmd.op     = OP_RD_A;
              state_next = S_SW_B;
            end
          end
          MODE_RESET: state_next = S_RS;
          default:    state_next = S_FINISH;
        endcase
      end
      // Select: one read and one emit per pick.
      S_SEL: begin
        if (flags.out_free) begin
          cmd.op     = OP_SEL_EMIT;
          state_next = flags.sel_last ? S_IDLE : S_SEL_RD;
        end
      end
      S_SEL_RD: state_next = S_SEL;
      // Set priority: close the gap at the old slot.
      S_SP_CAP: begin
        cmd.op     = OP_CAP_P;
        state_next = S_RM;
      end
      S_RM: begin
        if (flags.rm_more) begin
          cmd.op     = OP_OH_RD_NEXT;
          state_next = S_RM_W;
        end else begin
          state_next = S_SCAN_INI;
        end
      end
      S_RM_W: begin
        cmd.op     = OP_SHIFT_DN;
        state_next = S_RM;
      end
      // Search for the insertion slot from the top.
      S_SCAN_INI: begin
        cmd.op     = OP_CLR_CUR;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: state_next = flags.scan_more ? S_SCAN_PR : S_INS_INI;
      S_SCAN_PR: begin
        cmd.op     = OP_PR_RD_H;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (flags.cmp_hit) begin
          cmd.op     = OP_INC_CUR;
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_INS_INI;
        end
      end
      // Open a gap at the slot and place the entry.
      S_INS_INI: begin
        cmd.op     = OP_INS_INIT;
        state_next = S_INS;
      end
      S_INS: begin
        if (flags.ins_more) begin
          cmd.op     = OP_OH_RD_PREV;
          state_next = S_INS_W;
        end else begin
          cmd.op     = OP_PLACE;
          state_next = S_FINISH;
        end
      end
      S_INS_W: begin
        cmd.op     = OP_SHIFT_UP;
        state_next = S_INS;
      end
      // Truncate: compact the order keeping only surviving handles.
      S_TR_RD: begin
        if (flags.loop_more) begin
          state_next = S_TR_W;
        end else begin
          cmd.op     = OP_SET_N;
          state_next = S_FINISH;
        end
      end
      S_TR_W: begin
        cmd.op     = OP_TRUNC_STEP;
        state_next = S_TR_RD;
      end
      // Swap: read both entries, then write them crossed.
      S_SW_B: begin
        cmd.op     = OP_RD_B;
        state_next = S_SW_C;
      end
      S_SW_C: begin
        cmd.op     = OP_CAP_B;
        state_next = S_SW_1;
      end
      S_SW_1: begin
        cmd.op     = OP_SWAP_W1;
        state_next = S_SW_2;
      end
      S_SW_2: begin
        cmd.op     = OP_SWAP_W2;
        state_next = S_FINISH;
      end
      // Reset priorities: one entry per cycle.
      S_RS: begin
        if (flags.loop_more) begin
          cmd.op = OP_RST_STEP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (flags.out_free) begin
          cmd.op     = OP_EMIT_STATUS;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/priority_table_topk_selector.sv
// ============================================================================
// priority_table_topk_selector: sorted priority table with top-k selection
// Keeps entries in descending priority order and answers batch selects,
// priority updates, appends, truncation, swaps and priority resets.
//
//   channel  dir  fields
//   req      in   mode, handle_a, handle_b, priority_key, pick_count, new_count
//   rsp      out  picked_handle, last, status
//
// One request is processed at a time; the next is accepted once its last
// result is in the result register. A select reads and emits its picks in turn.
// Set priority, append and truncate walk the order memory one slot at a
// time; swap reads both entries and then writes them crossed, and reset
// priorities rewrites every entry in turn.
// Of the table state, reset clears the entry count only; no clearing pass is needed.
// A stalled result channel holds the sequencer until the register frees.
// ============================================================================
module priority_table_topk_selector import ptk_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int MAX_BATCH = MAX_BATCH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ptk_in_if.sink    req,
  ptk_out_if.source rsp
);

  cmd_t   cmd;
  flags_t flags;

  ptk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_mode  (req.payload.mode),
    .flags    (flags),
    .cmd      (cmd)
  );

  ptk_datapath #(
    .CAPACITY  (CAPACITY),
    .MAX_BATCH (MAX_BATCH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (req.payload),
    .flags     (flags),
    .out_item  (rsp.payload),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready)
  );

endmodule
